>>> src/nsc_pkg.sv
// Shared word types and byte-position constants for the nibble-sum checksum rewriter.
package nsc_pkg;

    localparam int MSG_BYTES = 32;
    localparam int POS_W     = $clog2(MSG_BYTES);
    localparam int NIB_W     = 4;

    // Byte positions that bound each checksum group.
    localparam logic [POS_W-1:0] POS_FIRST_LO  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_FIRST_HI  = POS_W'(7);
    localparam logic [POS_W-1:0] POS_SECOND_LO = POS_W'(8);
    localparam logic [POS_W-1:0] POS_SECOND_HI = POS_W'(15);
    localparam logic [POS_W-1:0] POS_THIRD_LO  = POS_W'(16);
    localparam logic [POS_W-1:0] POS_THIRD_HI  = POS_W'(19);
    localparam logic [POS_W-1:0] POS_CHECK_A   = POS_W'(20);
    localparam logic [POS_W-1:0] POS_CHECK_B   = POS_W'(21);
    localparam logic [POS_W-1:0] POS_FOURTH_LO = POS_W'(22);
    localparam logic [POS_W-1:0] POS_FOURTH_HI = POS_W'(23);
    localparam logic [POS_W-1:0] POS_FIFTH_LO  = POS_W'(24);
    localparam logic [POS_W-1:0] POS_FIFTH_HI  = POS_W'(30);
    localparam logic [POS_W-1:0] POS_LAST      = POS_W'(31);

    localparam logic [7:0] BYTE_ALL_ONES = 8'hFF;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       start_flag;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_message;
        logic       checksums_ok;
    } out_word_t;

endpackage

>>> src/nsc_core.sv
// Checksum state and per-byte rewrite logic for the nibble-sum checksum rewriter.
module nsc_core
    import nsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  in_word_t  in_word,
    output out_word_t result
);

    logic [POS_W-1:0] position_reg, position_next;
    logic [NIB_W-1:0] sum_first_reg, sum_first_next;
    logic [NIB_W-1:0] sum_second_reg, sum_second_next;
    logic [NIB_W-1:0] sum_third_reg, sum_third_next;
    logic [NIB_W-1:0] sum_fourth_reg, sum_fourth_next;
    logic [NIB_W-1:0] sum_fifth_reg, sum_fifth_next;
    logic             held_ff_reg, held_ff_next;
    logic             match_reg, match_next;

    logic [POS_W-1:0] pos;
    logic             clear;
    logic [NIB_W-1:0] lo, hi;
    logic [NIB_W-1:0] s1, s2, s3, s4, s5;
    logic             held_ff, match;

    // Position of this word; a new message clears the running state.
    always_comb
    begin
        pos     = in_word.start_flag ? '0 : position_reg;
        clear   = (pos == POS_FIRST_LO);
        lo      = in_word.msg_byte[NIB_W-1:0];
        hi      = in_word.msg_byte[7:NIB_W];
        s1      = clear ? '0 : sum_first_reg;
        s2      = clear ? '0 : sum_second_reg;
        s3      = clear ? '0 : sum_third_reg;
        s4      = clear ? '0 : sum_fourth_reg;
        s5      = clear ? '0 : sum_fifth_reg;
        held_ff = clear ? 1'b0 : held_ff_reg;
        match   = clear ? 1'b1 : match_reg;
    end

    // Accumulate the nibble sums and rewrite the checksum bytes.
    // Only the low nibble of each sum is ever used, so the sums are kept modulo 16.
    always_comb
    begin
        sum_first_next  = s1;
        sum_second_next = s2;
        sum_third_next  = s3;
        sum_fourth_next = s4;
        sum_fifth_next  = s5;
        held_ff_next    = held_ff;
        match_next      = match;
        position_next   = pos + POS_W'(1);
        result.out_byte        = in_word.msg_byte;
        result.last_of_message = 1'b0;
        result.checksums_ok    = 1'b0;
        case (pos) inside
            [POS_FIRST_LO:POS_FIRST_HI]:
                sum_first_next = s1 + lo + hi;
            [POS_SECOND_LO:POS_SECOND_HI]:
                sum_second_next = s2 + lo + hi;
            [POS_THIRD_LO:POS_THIRD_HI]:
                sum_third_next = s3 + lo + hi;
            POS_CHECK_A:
            begin
                sum_third_next  = s3 + lo;
                held_ff_next    = (in_word.msg_byte == BYTE_ALL_ONES);
                match_next      = match && (s1 == hi);
                result.out_byte = {s1, lo};
            end
            POS_CHECK_B:
            begin
                match_next = match && (s2 == lo) && (s3 == hi)
                             && !(held_ff && (in_word.msg_byte == BYTE_ALL_ONES));
                result.out_byte = {s3, s2};
            end
            [POS_FOURTH_LO:POS_FOURTH_HI]:
                sum_fourth_next = s4 + lo + hi;
            [POS_FIFTH_LO:POS_FIFTH_HI]:
                sum_fifth_next = s5 + lo + hi;
            default:
            begin
                result.out_byte        = {s5, s4};
                result.last_of_message = 1'b1;
                result.checksums_ok    = match && (s4 == lo) && (s5 == hi);
            end
        endcase
    end

    // State advances only when the word moves into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg   <= '0;
            sum_first_reg  <= '0;
            sum_second_reg <= '0;
            sum_third_reg  <= '0;
            sum_fourth_reg <= '0;
            sum_fifth_reg  <= '0;
            held_ff_reg    <= 1'b0;
            match_reg      <= 1'b1;
        end
        else if (advance)
        begin
            position_reg   <= position_next;
            sum_first_reg  <= sum_first_next;
            sum_second_reg <= sum_second_next;
            sum_third_reg  <= sum_third_next;
            sum_fourth_reg <= sum_fourth_next;
            sum_fifth_reg  <= sum_fifth_next;
            held_ff_reg    <= held_ff_next;
            match_reg      <= match_next;
        end
    end

endmodule

>>> src/nibble_sum_checksum_rewriter_top.sv
// Top level of the nibble-sum checksum rewriter: input register, core and result register.
//
// Usage: a 32-byte message enters one byte per word on the in channel
// (in_valid/in_ready/in_word); start_flag marks byte 0 and restarts the count.
// Each input word gives exactly one result word on the out channel
// (out_valid/out_ready/out_word). Bytes 20, 21 and 31 leave with their
// checksum nibbles rewritten; the word for byte 31 carries last_of_message
// and checksums_ok.
// A word passes from the input register through the core into the result
// register. Throughput is one word per cycle while the receiver keeps
// taking results; a stall holds the flow as described below.
// Reset empties both registers, puts the position at byte 0 and clears
// the sums. When the receiver stalls, the result register holds its word,
// the input register takes one more word, and in_ready then falls until
// the result is taken.
module nibble_sum_checksum_rewriter_top
    import nsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word
);

    logic      in_valid_reg;
    in_word_t  in_word_reg;
    logic      out_valid_reg;
    out_word_t out_word_reg;
    out_word_t result;
    logic      advance;

    // A word moves on when the result register is empty or being emptied.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_word_reg <= in_word;
    end

    nsc_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .in_word (in_word_reg),
        .result  (result)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_word_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule
